/* rtl/trr_pkg.sv */
// ----------------------------------------------------------------------------
// trr_pkg: shared types and constants of the two-way ranging responder
// Frame header constants, function codes, action codes, register indexes
// and the payload structs of the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package trr_pkg;

	// expected frame header words
	localparam logic [15:0] FC_EXPECTED   = 16'h8841;
	localparam logic [15:0] PAN_EXPECTED  = 16'hDECA;
	localparam logic [15:0] DEST_EXPECTED = 16'h4157;
	localparam logic [15:0] SRC_EXPECTED  = 16'h4556;

	// function codes
	localparam logic [7:0] CODE_POLL  = 8'h61;
	localparam logic [7:0] CODE_FINAL = 8'h69;

	// operation codes
	localparam logic OP_GOOD  = 1'b0;
	localparam logic OP_ERROR = 1'b1;

	// result actions
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_RESP   = 2'd1;
	localparam logic [1:0] ACT_REPORT = 2'd2;
	localparam logic [1:0] ACT_REJECT = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SIDED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLY_DELAY  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANT_DELAY    = 2'd3;

	// register reset values
	localparam logic        RST_DOUBLE_SIDED = 1'b1;
	localparam logic [7:0]  RST_NODE_ID      = 8'd0;
	localparam logic [15:0] RST_REPLY_DELAY  = 16'd1500;
	localparam logic [15:0] RST_ANT_DELAY    = 16'd16436;

	// arithmetic widths
	localparam int TS_W   = 40;
	localparam int WORD_W = 32;
	localparam int PROD_W = 2 * WORD_W;
	localparam int DEN_W  = WORD_W + 2;

	typedef struct packed {
		logic        operation;
		logic [15:0] frame_control;
		logic [7:0]  target_id;
		logic [15:0] pan_word;
		logic [15:0] dest_word;
		logic [15:0] src_word;
		logic [7:0]  function_code;
		logic [39:0] rx_stamp;
		logic [39:0] last_tx_stamp;
		logic [31:0] peer_poll_tx;
		logic [31:0] peer_resp_rx;
		logic [31:0] peer_final_tx;
	} req_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] delayed_tx_time;
		logic [31:0] embed_poll_rx;
		logic [31:0] embed_resp_tx;
		logic [31:0] flight_time;
	} rsp_t;

endpackage

`default_nettype wire

/* rtl/trr_req_if.sv */
// ----------------------------------------------------------------------------
// trr_req_if: receive event channel
// Valid/ready channel carrying one received-frame event per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface trr_req_if;
	import trr_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/trr_rsp_if.sv */
// ----------------------------------------------------------------------------
// trr_rsp_if: result channel
// Valid/ready channel carrying one ranging result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface trr_rsp_if;
	import trr_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/trr_mul.sv */
// ----------------------------------------------------------------------------
// trr_mul: shared 32x32 multiplier
// Unsigned product, registered at the output; used once per operand pair.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_mul (
	input  wire logic                         clk,
	input  wire logic [trr_pkg::WORD_W-1:0]   a,
	input  wire logic [trr_pkg::WORD_W-1:0]   b,
	output      logic [trr_pkg::PROD_W-1:0]   p
);
	import trr_pkg::*;

	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;
endmodule

`default_nettype wire

/* rtl/trr_div.sv */
// ----------------------------------------------------------------------------
// trr_div: radix-2 restoring divider
// 64-bit numerator by 34-bit denominator, one quotient bit per cycle.
// Only the low 32 quotient bits are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [trr_pkg::PROD_W-1:0]  num,
	input  wire logic [trr_pkg::DEN_W-1:0]   den,
	output      logic                        done,
	output      logic [trr_pkg::WORD_W-1:0]  quo
);
	import trr_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [WORD_W-1:0]  quo_q;

	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               qbit;

	// one restoring step: shift in next numerator bit, subtract if it fits
	always_comb begin
		trial = {rem_q, num_q[PROD_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PROD_W-2:0], 1'b0};
			rem_q <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

`default_nettype wire

/* rtl/trr_ranging_ctl.sv */
// ----------------------------------------------------------------------------
// trr_ranging_ctl: header check and response scheduling
// Decodes one receive event: header match, frame kind, scheduled response
// time and the four 32-bit wrapped interval differences of a final.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_ranging_ctl (
	input  wire logic                       double_sided,
	input  wire logic [7:0]                 node_id,
	input  wire logic [15:0]                reply_delay_uus,
	input  wire logic                       awaiting,
	input  wire logic [trr_pkg::TS_W-1:0]   saved_poll_rx,
	input  wire trr_pkg::req_t              req,
	output      logic                       good_poll,
	output      logic                       start_final,
	output      logic                       single_resp,
	output      logic [trr_pkg::WORD_W-1:0] sched,
	output      logic [trr_pkg::WORD_W-1:0] round_a,
	output      logic [trr_pkg::WORD_W-1:0] round_b,
	output      logic [trr_pkg::WORD_W-1:0] reply_a,
	output      logic [trr_pkg::WORD_W-1:0] reply_b
);
	import trr_pkg::*;

	logic            hdr_ok;
	logic            good;
	logic [TS_W:0]   sum;
	logic [WORD_W-1:0] resp_tx;

	always_comb begin
		hdr_ok = (req.frame_control == FC_EXPECTED) && (req.target_id == node_id)
			&& (req.pan_word == PAN_EXPECTED) && (req.dest_word == DEST_EXPECTED)
			&& (req.src_word == SRC_EXPECTED);
		good = (req.operation == OP_GOOD) && hdr_ok;

		good_poll   = good && (req.function_code == CODE_POLL) && (!double_sided || !awaiting);
		single_resp = good_poll && !double_sided;
		start_final = good && double_sided && awaiting && (req.function_code == CODE_FINAL);

		// rx + delay * 65536, 41 bits wide, then >> 8
		sum   = {1'b0, req.rx_stamp} + (TS_W+1)'({reply_delay_uus, 16'h0000});
		sched = sum[WORD_W+7:8];

		resp_tx = req.last_tx_stamp[WORD_W-1:0];
		round_b = req.rx_stamp[WORD_W-1:0] - resp_tx;
		reply_b = resp_tx - saved_poll_rx[WORD_W-1:0];
		round_a = req.peer_resp_rx - req.peer_poll_tx;
		reply_a = req.peer_final_tx - req.peer_resp_rx;
	end
endmodule

`default_nettype wire

/* rtl/twr_ranging_responder_unit.sv */
// ----------------------------------------------------------------------------
// twr_ranging_responder_unit: UWB two-way ranging, responder side
// Checks received frames, schedules poll responses and computes the
// asymmetric double-sided time of flight with exact integer arithmetic.
// ----------------------------------------------------------------------------
// One event is taken per transfer on req and yields exactly one result on
// rsp. Ready is high only while the sequencer is idle. A poll, an error or
// any frame that ends the exchange goes from the transfer straight to the
// result register load. A valid final in double-sided mode passes these
// steps from transfer to the next ready: the transfer, which registers the
// interval differences, the shared 32x32 multiplier (Ra*Rb, then Da*Db),
// the 64-bit subtract and sign check, the radix-2 divider (64 quotient
// bits, one per cycle, then its done flag), and the result load; a rejected
// numerator or denominator skips the divider. The result sits in an output
// register, so a waiting result does not hold the next event back unless a
// new result is ready before the old one is taken. Configuration writes
// (cfg_we, cfg_idx, cfg_data) take effect at once and belong in idle
// periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module twr_ranging_responder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [trr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [trr_pkg::CFG_DATA_W-1:0] cfg_data,
	trr_req_if.sink                            req,
	trr_rsp_if.source                          rsp
);
	import trr_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;  // Ra*Rb on the multiplier, denominator sum
	localparam logic [2:0] S_MUL2 = 3'd2;  // Da*Db on the multiplier, Ra*Rb captured
	localparam logic [2:0] S_SUB  = 3'd3;  // numerator and sign check, divider start
	localparam logic [2:0] S_DIV  = 3'd4;  // divider running
	localparam logic [2:0] S_FIN  = 3'd5;  // load result register

	logic [2:0]         state_q;

	// configuration registers
	logic               double_sided_q;
	logic [7:0]         node_id_q;
	logic [15:0]        reply_delay_q;
	logic [15:0]        ant_delay_q;

	// ranging state
	logic               awaiting_q;
	logic [TS_W-1:0]    saved_poll_rx_q;

	// per-item working registers
	logic [1:0]         res_action_q;
	logic               res_single_q;
	logic [WORD_W-1:0]  res_delayed_q;
	logic [WORD_W-1:0]  res_poll_rx_q;
	logic [WORD_W-1:0]  res_flight_q;
	logic [WORD_W-1:0]  round_a_q;
	logic [WORD_W-1:0]  round_b_q;
	logic [WORD_W-1:0]  reply_a_q;
	logic [WORD_W-1:0]  reply_b_q;
	logic [DEN_W-1:0]   den_q;
	logic [PROD_W-1:0]  prod_r_q;

	// output register
	logic               out_valid_q;
	rsp_t               out_q;

	// decode outputs
	logic               good_poll;
	logic               start_final;
	logic               single_resp;
	logic [WORD_W-1:0]  sched;
	logic [WORD_W-1:0]  round_a;
	logic [WORD_W-1:0]  round_b;
	logic [WORD_W-1:0]  reply_a;
	logic [WORD_W-1:0]  reply_b;

	// shared arithmetic
	logic [WORD_W-1:0]  mul_a;
	logic [WORD_W-1:0]  mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [PROD_W:0]    num_ext;
	logic               reject;
	logic               div_start;
	logic               div_done;
	logic [WORD_W-1:0]  div_quo;

	logic               acc;
	logic               out_free;
	logic [WORD_W-1:0]  embed_resp;

	assign acc      = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	trr_ranging_ctl u_ctl (
		.double_sided    (double_sided_q),
		.node_id         (node_id_q),
		.reply_delay_uus (reply_delay_q),
		.awaiting        (awaiting_q),
		.saved_poll_rx   (saved_poll_rx_q),
		.req             (req.payload),
		.good_poll       (good_poll),
		.start_final     (start_final),
		.single_resp     (single_resp),
		.sched           (sched),
		.round_a         (round_a),
		.round_b         (round_b),
		.reply_a         (reply_a),
		.reply_b         (reply_b)
	);

	// multiplier operands: round trip pair first, reply pair second
	assign mul_a = (state_q == S_MUL1) ? round_a_q : reply_a_q;
	assign mul_b = (state_q == S_MUL1) ? round_b_q : reply_b_q;

	trr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// numerator Ra*Rb - Da*Db; borrow or zero means not positive
	assign num_ext   = {1'b0, prod_r_q} - {1'b0, mul_p};
	assign reject    = num_ext[PROD_W] || (num_ext[PROD_W-1:0] == '0) || (den_q == '0);
	assign div_start = (state_q == S_SUB) && !reject;

	trr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_ext[PROD_W-1:0]),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// predicted response transmit time: (sched with bit 0 cleared) << 8, plus antenna delay
	assign embed_resp = {res_delayed_q[23:1], 9'h000} + WORD_W'(ant_delay_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_sided_q <= RST_DOUBLE_SIDED;
			node_id_q      <= RST_NODE_ID;
			reply_delay_q  <= RST_REPLY_DELAY;
			ant_delay_q    <= RST_ANT_DELAY;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DOUBLE_SIDED: double_sided_q <= cfg_data[0];
				CFG_NODE_ID:      node_id_q      <= cfg_data[7:0];
				CFG_REPLY_DELAY:  reply_delay_q  <= cfg_data;
				CFG_ANT_DELAY:    ant_delay_q    <= cfg_data;
			endcase
		end
	end

	// sequencer and ranging state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			awaiting_q      <= 1'b0;
			saved_poll_rx_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						// every event ends a pending exchange unless it starts one
						awaiting_q <= good_poll && double_sided_q;
						if (good_poll) begin
							saved_poll_rx_q <= req.payload.rx_stamp;
						end
						state_q <= start_final ? S_MUL1 : S_FIN;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SUB;
				S_SUB:  state_q <= reject ? S_FIN : S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			res_action_q  <= good_poll ? ACT_RESP : ACT_NONE;
			res_single_q  <= single_resp;
			res_delayed_q <= good_poll ? sched : '0;
			res_poll_rx_q <= single_resp ? req.payload.rx_stamp[WORD_W-1:0] : '0;
			res_flight_q  <= '0;
			round_a_q     <= round_a;
			round_b_q     <= round_b;
			reply_a_q     <= reply_a;
			reply_b_q     <= reply_b;
		end
		if (state_q == S_MUL1) begin
			den_q <= DEN_W'(round_a_q) + DEN_W'(round_b_q) + DEN_W'(reply_a_q)
				+ DEN_W'(reply_b_q);
		end
		if (state_q == S_MUL2) begin
			prod_r_q <= mul_p;
		end
		if ((state_q == S_SUB) && reject) begin
			res_action_q <= ACT_REJECT;
		end
		if ((state_q == S_DIV) && div_done) begin
			res_action_q <= ACT_REPORT;
			res_flight_q <= div_quo;
		end
		if ((state_q == S_FIN) && out_free) begin
			out_q.action          <= res_action_q;
			out_q.delayed_tx_time <= res_delayed_q;
			out_q.embed_poll_rx   <= res_poll_rx_q;
			out_q.embed_resp_tx   <= res_single_q ? embed_resp : '0;
			out_q.flight_time     <= res_flight_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside divide state");

	// an accepted event always takes the sequencer out of idle in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q != S_IDLE))
		else $error("sequencer idle right after a transfer");

	// only a report carries a flight time
	a_flight_only_report: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.payload.action != ACT_REPORT)) |-> (rsp.payload.flight_time == '0))
		else $error("flight time on a non-report result");

	// a response in single-sided mode never leaves an exchange open
	a_single_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !double_sided_q) |=> !awaiting_q)
		else $error("exchange left open in single-sided mode");
endmodule

`default_nettype wire
